// ===== rtl/dual_wheel_pid_speed_control_core_assert.svh =====
// Assertion macros for the speed controller.
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_CORE_ASSERT_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define DWPID_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dwpid: same-cycle check failed");
`define DWPID_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dwpid: next-cycle check failed");
`else
`define DWPID_ASSERT_IMPLIES(label, ante, cons)
`define DWPID_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/dwpid_pkg.sv =====
`default_nettype none

package dwpid_pkg;

    localparam int SUM_WIDTH_DEFAULT = 48;
    localparam int DRIVE_LIMIT       = 100;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int GAIN_W      = 16;
    localparam int SCALE_W     = 32;
    localparam int COUNT_W     = 16;
    localparam int SPEED_W     = 32;
    localparam int DRIVE_W     = 8;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RESET   = 16'd25600;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RESET  = 16'd25600;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RESET  = 16'd0;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RESET = 32'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN_LEFT,
        REG_PROP_GAIN_RIGHT,
        REG_INTEG_GAIN_LEFT,
        REG_INTEG_GAIN_RIGHT,
        REG_DERIV_GAIN_LEFT,
        REG_DERIV_GAIN_RIGHT,
        REG_SPEED_SCALE_LEFT,
        REG_SPEED_SCALE_RIGHT
    } cfg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [SCALE_W-1:0] speed_scale;
    } lane_cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SPEED,
        ST_ERROR,
        ST_INTEG,
        ST_DERIV,
        ST_ILO,
        ST_IHI,
        ST_ICOMB,
        ST_IACC,
        ST_FINISH
    } state_t;

    typedef enum logic [3:0] {
        DP_IDLE,
        DP_LOAD_SAMPLE,
        DP_LOAD_TARGET,
        DP_MUL_SPEED,
        DP_ERROR,
        DP_INTEG,
        DP_MUL_D,
        DP_MUL_ILO,
        DP_MUL_IHI,
        DP_ICOMB,
        DP_IACC,
        DP_FINISH
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t cmd;
    } dwpid_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/dwpid_sample_if.sv =====
`default_nettype none

interface dwpid_sample_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [15:0] count_left;
    logic signed [15:0] count_right;
    logic signed [31:0] target_left;
    logic signed [31:0] target_right;

    modport source (
        output valid, op, count_left, count_right, target_left, target_right,
        input  ready
    );
    modport sink (
        input  valid, op, count_left, count_right, target_left, target_right,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/dwpid_drive_if.sv =====
`default_nettype none

interface dwpid_drive_if;
    logic              valid;
    logic              ready;
    logic signed [7:0] drive_left;
    logic signed [7:0] drive_right;

    modport source (
        output valid, drive_left, drive_right,
        input  ready
    );
    modport sink (
        input  valid, drive_left, drive_right,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/dwpid_cfg.sv =====
`default_nettype none

module dwpid_cfg
    import dwpid_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output lane_cfg_t                   cfg_left,
    output lane_cfg_t                   cfg_right
);

    lane_cfg_t left_reg,  left_next;
    lane_cfg_t right_reg, right_next;

    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_PROP_GAIN_LEFT:    left_next.prop_gain    = cfg_data[GAIN_W-1:0];
                REG_PROP_GAIN_RIGHT:   right_next.prop_gain   = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN_LEFT:   left_next.integ_gain   = cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN_RIGHT:  right_next.integ_gain  = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN_LEFT:   left_next.deriv_gain   = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN_RIGHT:  right_next.deriv_gain  = cfg_data[GAIN_W-1:0];
                REG_SPEED_SCALE_LEFT:  left_next.speed_scale  = cfg_data[SCALE_W-1:0];
                REG_SPEED_SCALE_RIGHT: right_next.speed_scale = cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '{PROP_GAIN_RESET, INTEG_GAIN_RESET, DERIV_GAIN_RESET,
                           SPEED_SCALE_RESET};
            right_reg <= '{PROP_GAIN_RESET, INTEG_GAIN_RESET, DERIV_GAIN_RESET,
                           SPEED_SCALE_RESET};
        end
        else
        begin
            left_reg  <= left_next;
            right_reg <= right_next;
        end
    end

    assign cfg_left  = left_reg;
    assign cfg_right = right_reg;

endmodule

`default_nettype wire

// ===== rtl/dwpid_ctrl.sv =====
`default_nettype none

module dwpid_ctrl
    import dwpid_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  in_op,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output dwpid_ctrl_t ctrl
);

    `include "dual_wheel_pid_speed_control_core_assert.svh"

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ctrl.cmd       = DP_IDLE;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op)
                    begin
                        ctrl.cmd = DP_LOAD_TARGET;
                    end
                    else
                    begin
                        ctrl.cmd   = DP_LOAD_SAMPLE;
                        state_next = ST_SPEED;
                    end
                end
            end
            ST_SPEED:
            begin
                ctrl.cmd   = DP_MUL_SPEED;
                state_next = ST_ERROR;
            end
            ST_ERROR:
            begin
                ctrl.cmd   = DP_ERROR;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                ctrl.cmd   = DP_INTEG;
                state_next = ST_DERIV;
            end
            ST_DERIV:
            begin
                ctrl.cmd   = DP_MUL_D;
                state_next = ST_ILO;
            end
            ST_ILO:
            begin
                ctrl.cmd   = DP_MUL_ILO;
                state_next = ST_IHI;
            end
            ST_IHI:
            begin
                ctrl.cmd   = DP_MUL_IHI;
                state_next = ST_ICOMB;
            end
            ST_ICOMB:
            begin
                ctrl.cmd   = DP_ICOMB;
                state_next = ST_IACC;
            end
            ST_IACC:
            begin
                ctrl.cmd   = DP_IACC;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // output slot must be free before the drive registers change
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.cmd       = DP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    `DWPID_ASSERT_NEXT(a_sample_starts, in_valid && in_ready && !in_op, state_reg == ST_SPEED)
    `DWPID_ASSERT_NEXT(a_command_no_beat, in_valid && in_ready && in_op && !out_valid_reg, !out_valid_reg)
    `DWPID_ASSERT_IMPLIES(a_beat_from_finish, $rose(out_valid_reg), $past(state_reg) == ST_FINISH)
    `DWPID_ASSERT_NEXT(a_finish_waits, state_reg == ST_FINISH && out_valid_reg && !out_ready, state_reg == ST_FINISH)

endmodule

`default_nettype wire

// ===== rtl/dwpid_lane.sv =====
`default_nettype none

module dwpid_lane
    import dwpid_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dwpid_ctrl_t               ctrl,
    input  wire lane_cfg_t                 lcfg,
    input  wire logic signed [COUNT_W-1:0] count,
    input  wire logic signed [SPEED_W-1:0] target,
    output logic signed [DRIVE_W-1:0]      drive
);

    localparam int MUL_A_W = GAIN_W + 1;
    localparam int MUL_B_W = SCALE_W + 2;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ILO_W   = GAIN_W + 32;
    localparam int ERR_W   = PROD_W + 1;
    localparam int DIFF_W  = SPEED_W + 1;
    localparam int SW1     = SUM_WIDTH + 1;
    localparam int HI_W    = SUM_WIDTH - 32;
    localparam int IP_W    = SUM_WIDTH + GAIN_W + 2;
    localparam int CMP_W   = (IP_W > 62) ? IP_W : 62;
    localparam int ACC_W   = 64;
    localparam int FRAC_W  = 24;

    localparam logic signed [ERR_W-1:0] E_MAX =
        {{(ERR_W-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
    localparam logic signed [ERR_W-1:0] E_MIN =
        {{(ERR_W-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};
    localparam logic signed [SW1-1:0] SUM_MAX = {2'b00, {(SUM_WIDTH-1){1'b1}}};
    localparam logic signed [SW1-1:0] SUM_MIN = {2'b11, {(SUM_WIDTH-1){1'b0}}};
    localparam logic signed [CMP_W-1:0] CAP     = {{(CMP_W-61){1'b0}}, 1'b1, 60'd0};
    localparam logic signed [CMP_W-1:0] NEG_CAP = -CAP;
    localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(DRIVE_LIMIT);
    localparam logic signed [ACC_W-1:0] DRV_MIN = -DRV_MAX;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS = {{(ACC_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

    // loop state
    logic signed [SPEED_W-1:0]   target_reg, target_next;
    logic signed [SUM_WIDTH-1:0] sum_reg,    sum_next;
    logic signed [SPEED_W-1:0]   last_reg,   last_next;

    // working registers
    logic signed [COUNT_W-1:0] count_reg, count_next;
    logic signed [SPEED_W-1:0] e_reg,     e_next;
    logic signed [DIFF_W-1:0]  diff_reg,  diff_next;
    logic signed [PROD_W-1:0]  prod_reg,  prod_next;
    logic        [ILO_W-1:0]   ilo_reg,   ilo_next;
    logic signed [IP_W-1:0]    ip_reg,    ip_next;
    logic signed [ACC_W-1:0]   acc_reg,   acc_next;
    logic signed [DRIVE_W-1:0] drive_reg, drive_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [ERR_W-1:0]   err_wide;
    logic signed [SW1-1:0]     sum_wide;
    logic signed [CMP_W-1:0]   ip_wide;
    logic signed [CMP_W-1:0]   ip_clamp;
    logic signed [ACC_W-1:0]   q_wide;
    logic signed [ACC_W-1:0]   q_clamp;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.cmd)
            DP_MUL_SPEED:
            begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = $signed({2'b00, lcfg.speed_scale});
            end
            DP_INTEG:
            begin
                mul_a = $signed({1'b0, lcfg.prop_gain});
                mul_b = MUL_B_W'(e_reg);
            end
            DP_MUL_D:
            begin
                mul_a = $signed({1'b0, lcfg.deriv_gain});
                mul_b = MUL_B_W'(diff_reg);
            end
            DP_MUL_ILO:
            begin
                mul_a = $signed({1'b0, lcfg.integ_gain});
                mul_b = $signed({2'b00, sum_reg[31:0]});
            end
            DP_MUL_IHI:
            begin
                mul_a = $signed({1'b0, lcfg.integ_gain});
                mul_b = MUL_B_W'($signed(sum_reg[SUM_WIDTH-1:SUM_WIDTH-HI_W]));
            end
            default: ;
        endcase
    end

    always_comb
    begin
        err_wide = ERR_W'(target_reg) - ERR_W'(prod_reg);
        sum_wide = SW1'(sum_reg) + SW1'(e_reg);
        ip_wide  = CMP_W'(ip_reg);
        if (ip_wide > CAP)
            ip_clamp = CAP;
        else if (ip_wide < NEG_CAP)
            ip_clamp = NEG_CAP;
        else
            ip_clamp = ip_wide;
        // truncate toward zero
        q_wide = (acc_reg + (acc_reg[ACC_W-1] ? ROUND_BIAS : ACC_W'(0))) >>> FRAC_W;
        if (q_wide > DRV_MAX)
            q_clamp = DRV_MAX;
        else if (q_wide < DRV_MIN)
            q_clamp = DRV_MIN;
        else
            q_clamp = q_wide;
    end

    always_comb
    begin
        target_next = target_reg;
        sum_next    = sum_reg;
        last_next   = last_reg;
        count_next  = count_reg;
        e_next      = e_reg;
        diff_next   = diff_reg;
        prod_next   = mul_a * mul_b;
        ilo_next    = ilo_reg;
        ip_next     = ip_reg;
        acc_next    = acc_reg;
        drive_next  = drive_reg;
        unique case (ctrl.cmd)
            DP_LOAD_SAMPLE:
            begin
                count_next = count;
            end
            DP_LOAD_TARGET:
            begin
                target_next = target;
                sum_next    = '0;
                last_next   = '0;
            end
            DP_ERROR:
            begin
                if (err_wide > E_MAX)
                    e_next = SPEED_W'(E_MAX);
                else if (err_wide < E_MIN)
                    e_next = SPEED_W'(E_MIN);
                else
                    e_next = SPEED_W'(err_wide);
            end
            DP_INTEG:
            begin
                if (sum_wide > SUM_MAX)
                    sum_next = SUM_WIDTH'(SUM_MAX);
                else if (sum_wide < SUM_MIN)
                    sum_next = SUM_WIDTH'(SUM_MIN);
                else
                    sum_next = SUM_WIDTH'(sum_wide);
                diff_next = DIFF_W'(e_reg) - DIFF_W'(last_reg);
                last_next = e_reg;
            end
            DP_MUL_D:
            begin
                acc_next = ACC_W'(prod_reg);
            end
            DP_MUL_ILO:
            begin
                acc_next = acc_reg - ACC_W'(prod_reg);
            end
            DP_MUL_IHI:
            begin
                ilo_next = prod_reg[ILO_W-1:0];
            end
            DP_ICOMB:
            begin
                ip_next = (IP_W'(prod_reg) <<< 32) + IP_W'($signed({1'b0, ilo_reg}));
            end
            DP_IACC:
            begin
                acc_next = acc_reg + ACC_W'(ip_clamp);
            end
            DP_FINISH:
            begin
                drive_next = DRIVE_W'(-q_clamp);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
            sum_reg    <= '0;
            last_reg   <= '0;
        end
        else
        begin
            target_reg <= target_next;
            sum_reg    <= sum_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        e_reg     <= e_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        ilo_reg   <= ilo_next;
        ip_reg    <= ip_next;
        acc_reg   <= acc_next;
        drive_reg <= drive_next;
    end

    assign drive = drive_reg;

endmodule

`default_nettype wire

// ===== rtl/dual_wheel_pid_speed_control_core.sv =====
// Two-wheel PID speed controller.
// sample channel: op 0 carries the encoder count change of each wheel for one
// period and yields one beat on the drive channel; op 1 loads new speed
// targets, clears both integrators and previous errors, and yields no beat.
// Configuration: gains and speed scales are written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce; they take effect on the next sample.
// One target command per cycle while idle; a new sample only once the last one
// is through. Each wheel's multiplier is shared within a nine-step sequence
// (speed, error, P, D, two integral partial products, combine, add, saturate).
// Both wheels run side by side in lanes of their own.
// The drive result sits in an output register; a new beat is taken while it
// waits, but the last step holds until the receiver has taken the old result.
// Reset: targets, integrators and previous errors go to zero, gains to their
// default values; no beat is pending.
`default_nettype none

module dual_wheel_pid_speed_control_core
    import dwpid_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    dwpid_sample_if.sink                sample,
    dwpid_drive_if.source               drive
);

    lane_cfg_t   cfg_left;
    lane_cfg_t   cfg_right;
    dwpid_ctrl_t ctrl;

    dwpid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_left  (cfg_left),
        .cfg_right (cfg_right)
    );

    dwpid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_op     (sample.op),
        .in_ready  (sample.ready),
        .out_valid (drive.valid),
        .out_ready (drive.ready),
        .ctrl      (ctrl)
    );

    dwpid_lane #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_lane_left (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .lcfg   (cfg_left),
        .count  (sample.count_left),
        .target (sample.target_left),
        .drive  (drive.drive_left)
    );

    dwpid_lane #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_lane_right (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .lcfg   (cfg_right),
        .count  (sample.count_right),
        .target (sample.target_right),
        .drive  (drive.drive_right)
    );

endmodule

`default_nettype wire

// ===== tb/sv/dwpid_drive_checker.sv =====
`default_nettype none

module dwpid_drive_checker
    import dwpid_pkg::*;
#(
    parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    dwpid_sample_if                     sample,
    dwpid_drive_if                      drive,
    output int                          mismatches,
    output int                          drives_pending,
    output int                          samples_seen,
    output int                          commands_seen,
    output int                          drives_checked
);

    localparam int LEFT  = 0;
    localparam int RIGHT = 1;

    localparam logic signed [127:0] ERR_MAX   = (128'sd1 <<< 31) - 1;
    localparam logic signed [127:0] ERR_MIN   = -(128'sd1 <<< 31);
    localparam logic signed [127:0] SUM_MAX   = (128'sd1 <<< (SUM_WIDTH - 1)) - 1;
    localparam logic signed [127:0] SUM_MIN   = -(128'sd1 <<< (SUM_WIDTH - 1));
    localparam logic signed [127:0] TERM_CAP  = 128'sd1 <<< 60;
    localparam logic signed [127:0] DRIVE_MAX = 128'(DRIVE_LIMIT);

    typedef struct packed {
        logic [DRIVE_W-1:0] left;
        logic [DRIVE_W-1:0] right;
    } drive_pair_t;

    lane_cfg_t                 lane_cfg     [2];
    logic signed [SPEED_W-1:0]   wheel_target [2];
    logic signed [SUM_WIDTH-1:0] wheel_sum    [2];
    logic signed [SPEED_W-1:0]   wheel_last   [2];
    drive_pair_t               expected_drives [$];

    function automatic logic [DRIVE_W-1:0] step_wheel(int side,
                                                       logic signed [COUNT_W-1:0] count);
        lane_cfg_t           c;
        logic signed [127:0] speed;
        logic signed [127:0] err;
        logic signed [127:0] acc;
        logic signed [127:0] diff;
        logic signed [127:0] iterm;
        logic signed [127:0] corr;
        logic signed [127:0] quo;
        c = lane_cfg[side];
        speed = count * $signed({1'b0, c.speed_scale});
        err = wheel_target[side] - speed;
        if (err > ERR_MAX)
        begin
            err = ERR_MAX;
        end
        if (err < ERR_MIN)
        begin
            err = ERR_MIN;
        end
        acc = wheel_sum[side] + err;
        if (acc > SUM_MAX)
        begin
            acc = SUM_MAX;
        end
        if (acc < SUM_MIN)
        begin
            acc = SUM_MIN;
        end
        wheel_sum[side] = acc[SUM_WIDTH-1:0];
        diff = err - wheel_last[side];
        wheel_last[side] = err[SPEED_W-1:0];
        iterm = $signed({1'b0, c.integ_gain}) * acc;
        if (iterm > TERM_CAP)
        begin
            iterm = TERM_CAP;
        end
        if (iterm < -TERM_CAP)
        begin
            iterm = -TERM_CAP;
        end
        corr = $signed({1'b0, c.prop_gain}) * err + iterm
             - $signed({1'b0, c.deriv_gain}) * diff;
        quo = (corr >= 0) ? (corr >>> 24) : -((-corr) >>> 24);
        if (quo > DRIVE_MAX)
        begin
            quo = DRIVE_MAX;
        end
        if (quo < -DRIVE_MAX)
        begin
            quo = -DRIVE_MAX;
        end
        quo = -quo;
        return quo[DRIVE_W-1:0];
    endfunction

    task automatic report_field(string field, logic [DRIVE_W-1:0] want,
                                logic [DRIVE_W-1:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
            begin
                $display("drive beat %0d: %s expected %0d, got %0d",
                         drives_checked, field, $signed(want), $signed(got));
            end
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_pair_t want;
        if (!rst_n)
        begin
            for (int i = LEFT; i <= RIGHT; i++)
            begin
                lane_cfg[i] = '{PROP_GAIN_RESET, INTEG_GAIN_RESET, DERIV_GAIN_RESET,
                                SPEED_SCALE_RESET};
                wheel_target[i] = '0;
                wheel_sum[i] = '0;
                wheel_last[i] = '0;
            end
            expected_drives.delete();
            mismatches = 0;
            samples_seen = 0;
            commands_seen = 0;
            drives_checked = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_PROP_GAIN_LEFT:    lane_cfg[LEFT].prop_gain    = cfg_data[GAIN_W-1:0];
                    REG_PROP_GAIN_RIGHT:   lane_cfg[RIGHT].prop_gain   = cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN_LEFT:   lane_cfg[LEFT].integ_gain   = cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN_RIGHT:  lane_cfg[RIGHT].integ_gain  = cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN_LEFT:   lane_cfg[LEFT].deriv_gain   = cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN_RIGHT:  lane_cfg[RIGHT].deriv_gain  = cfg_data[GAIN_W-1:0];
                    REG_SPEED_SCALE_LEFT:  lane_cfg[LEFT].speed_scale  = cfg_data[SCALE_W-1:0];
                    REG_SPEED_SCALE_RIGHT: lane_cfg[RIGHT].speed_scale = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (sample.valid && sample.ready)
            begin
                if (sample.op)
                begin
                    wheel_target[LEFT] = sample.target_left;
                    wheel_target[RIGHT] = sample.target_right;
                    for (int i = LEFT; i <= RIGHT; i++)
                    begin
                        wheel_sum[i] = '0;
                        wheel_last[i] = '0;
                    end
                    commands_seen++;
                end
                else
                begin
                    want.left = step_wheel(LEFT, sample.count_left);
                    want.right = step_wheel(RIGHT, sample.count_right);
                    expected_drives.push_back(want);
                    samples_seen++;
                end
            end
            if (drive.valid && drive.ready)
            begin
                if (expected_drives.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("drive beat %0d arrived with none outstanding", drives_checked);
                    end
                    mismatches++;
                end
                else
                begin
                    want = expected_drives.pop_front();
                    report_field("drive_left", want.left, drive.drive_left);
                    report_field("drive_right", want.right, drive.drive_right);
                end
                drives_checked++;
            end
        end
        drives_pending = expected_drives.size();
    end

endmodule

`default_nettype wire

// ===== tb/sv/dual_wheel_pid_speed_control_core_test.sv =====
`default_nettype none

module dual_wheel_pid_speed_control_core_test;
    import dwpid_pkg::*;

    localparam int RANDOM_ITEMS    = 1620;
    localparam int BLOCKS          = 9;
    localparam int SOAK_SAMPLES    = 120;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int DRAIN_CYCLES    = 12;
    localparam int CYCLE_LIMIT     = 3000000;

    typedef enum int {
        GAINS_MODERATE,
        GAINS_MAX,
        GAINS_ZERO,
        GAINS_FULL,
        GAINS_RESET
    } gain_setting_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    cfg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int drives_pending;
    int samples_seen;
    int commands_seen;
    int drives_checked;
    int src_idle_pct;
    int snk_idle_pct;
    int cycles;
    bit hold_req;

    dwpid_sample_if sample_ch ();
    dwpid_drive_if  drive_ch ();

    dual_wheel_pid_speed_control_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .drive     (drive_ch)
    );

    dwpid_drive_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample         (sample_ch),
        .drive          (drive_ch),
        .mismatches     (mismatches),
        .drives_pending (drives_pending),
        .samples_seen   (samples_seen),
        .commands_seen  (commands_seen),
        .drives_checked (drives_checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d drive beats outstanding",
                     cycles, drives_pending);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        drive_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                drive_ch.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            drive_ch.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // called and returns at a falling edge; valid is left high for back-to-back beats
    task automatic send_beat(logic op, logic [COUNT_W-1:0] cnt_l, logic [COUNT_W-1:0] cnt_r,
                             logic [SPEED_W-1:0] tgt_l, logic [SPEED_W-1:0] tgt_r);
        while ($urandom_range(99) < src_idle_pct)
        begin
            sample_ch.valid = 1'b0;
            @(negedge clk);
        end
        sample_ch.valid = 1'b1;
        sample_ch.op = op;
        sample_ch.count_left = cnt_l;
        sample_ch.count_right = cnt_r;
        sample_ch.target_left = tgt_l;
        sample_ch.target_right = tgt_r;
        @(posedge clk);
        while (!sample_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic drain();
        sample_ch.valid = 1'b0;
        while (drives_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] reg_value(gain_setting_t setting, cfg_index_t idx);
        bit is_scale;
        is_scale = (idx == REG_SPEED_SCALE_LEFT) || (idx == REG_SPEED_SCALE_RIGHT);
        case (setting)
            GAINS_MAX:
                return is_scale ? 32'hFFFF_FFFF : 32'h0000_FFFF;
            GAINS_ZERO:
                return '0;
            GAINS_FULL:
                return is_scale ? $urandom : $urandom_range(16'hFFFF);
            GAINS_RESET:
                if (is_scale)
                    return SPEED_SCALE_RESET;
                else if (idx == REG_DERIV_GAIN_LEFT || idx == REG_DERIV_GAIN_RIGHT)
                    return DERIV_GAIN_RESET;
                else
                    return PROP_GAIN_RESET;
            default:
                if (is_scale)
                    return $urandom_range(262144, 16384);
                else if (idx == REG_INTEG_GAIN_LEFT || idx == REG_INTEG_GAIN_RIGHT)
                    return $urandom_range(32);
                else
                    return $urandom_range(1024, 64);
        endcase
    endfunction

    task automatic load_gains(gain_setting_t setting);
        cfg_index_t idx;
        idx = idx.first();
        repeat (idx.num())
        begin
            write_reg(idx, reg_value(setting, idx));
            idx = idx.next();
        end
    endtask

    function automatic logic [SPEED_W-1:0] pick_target();
        int v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = (int'($urandom_range(400)) - 200) * 65536 + int'($urandom_range(65535));
        endcase
        return v;
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int v;
        case ($urandom_range(9))
            0: v = $urandom;
            1: v = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            default: v = int'($urandom_range(200)) - 100;
        endcase
        return v[COUNT_W-1:0];
    endfunction

    // mostly a target command followed by a run of samples; some raw noise
    task automatic run_block(int n);
        int sent;
        int len;
        sent = 0;
        while (sent < n)
        begin
            if ($urandom_range(19) == 0)
            begin
                send_beat(1'($urandom_range(1)), COUNT_W'($urandom), COUNT_W'($urandom),
                          $urandom, $urandom);
                sent++;
            end
            else
            begin
                send_beat(1'b1, COUNT_W'($urandom), COUNT_W'($urandom),
                          pick_target(), pick_target());
                len = $urandom_range(12, 2);
                repeat (len) send_beat(1'b0, pick_count(), pick_count(), $urandom, $urandom);
                sent += len + 1;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_PROP_GAIN_LEFT;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.op = 1'b0;
        sample_ch.count_left = '0;
        sample_ch.count_right = '0;
        sample_ch.target_left = '0;
        sample_ch.target_right = '0;
        hold_req = 1'b0;
        cycles = 0;
        src_idle_pct = 14;
        snk_idle_pct = 48;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // default gains: zero error, extreme counts, error clamp both ways
        send_beat(1'b0, 16'h0000, 16'h0000, $urandom, $urandom);
        send_beat(1'b0, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(1'b1, 16'h7FFF, 16'h8000, 32'h7FFF_FFFF, 32'h8000_0000);
        send_beat(1'b0, 16'h8000, 16'h7FFF, '0, '0);
        send_beat(1'b0, 16'h0000, 16'h0000, $urandom, $urandom);
        send_beat(1'b1, 16'h0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF);
        send_beat(1'b0, 16'h7FFF, 16'h8000, $urandom, $urandom);
        send_beat(1'b0, 16'hFFFF, 16'h0001, $urandom, $urandom);
        drain();

        // derivative path, zero and full scale
        write_reg(REG_PROP_GAIN_LEFT, 32'h0100);
        write_reg(REG_PROP_GAIN_RIGHT, 32'h0100);
        write_reg(REG_INTEG_GAIN_LEFT, 32'h0000);
        write_reg(REG_INTEG_GAIN_RIGHT, 32'h0000);
        write_reg(REG_DERIV_GAIN_LEFT, 32'hFFFF);
        write_reg(REG_DERIV_GAIN_RIGHT, 32'h0100);
        write_reg(REG_SPEED_SCALE_LEFT, 32'h0000_0000);
        write_reg(REG_SPEED_SCALE_RIGHT, 32'hFFFF_FFFF);
        send_beat(1'b1, 16'h1234, 16'hFEDC, 32'sd196608, -32'sd196608);
        send_beat(1'b0, 16'h0000, 16'h0000, $urandom, $urandom);
        send_beat(1'b0, 16'h0001, 16'hFFFF, $urandom, $urandom);
        send_beat(1'b0, 16'h0003, 16'hFFFD, $urandom, $urandom);
        send_beat(1'b0, 16'h8000, 16'h7FFF, $urandom, $urandom);
        send_beat(1'b1, 16'h0000, 16'h0000, 32'sd65536, 32'sd0);
        send_beat(1'b0, 16'h0000, 16'h0000, $urandom, $urandom);
        send_beat(1'b0, 16'h0000, 16'h0000, $urandom, $urandom);

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            drain();
            load_gains(gain_setting_t'(blk % 5));
            case (blk / 3)
                0:
                begin
                    src_idle_pct = 14;
                    snk_idle_pct = 48;
                end
                1:
                begin
                    src_idle_pct = 48;
                    snk_idle_pct = 14;
                end
                default:
                begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            if (blk == 6)
            begin
                hold_req = 1'b1;
            end
            run_block(RANDOM_ITEMS / BLOCKS);
        end

        // soak: hold the error at its clamp so the integral term dominates
        drain();
        write_reg(REG_PROP_GAIN_LEFT, 32'h0001);
        write_reg(REG_PROP_GAIN_RIGHT, 32'h0001);
        write_reg(REG_INTEG_GAIN_LEFT, 32'hFFFF);
        write_reg(REG_INTEG_GAIN_RIGHT, 32'hFFFF);
        write_reg(REG_DERIV_GAIN_LEFT, 32'h0000);
        write_reg(REG_DERIV_GAIN_RIGHT, 32'h0000);
        write_reg(REG_SPEED_SCALE_LEFT, SPEED_SCALE_RESET);
        write_reg(REG_SPEED_SCALE_RIGHT, SPEED_SCALE_RESET);
        send_beat(1'b1, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        repeat (SOAK_SAMPLES) send_beat(1'b0, 16'h8000, 16'h7FFF, $urandom, $urandom);
        repeat (8) send_beat(1'b0, 16'h7FFF, 16'h8000, $urandom, $urandom);
        send_beat(1'b1, '0, '0, '0, '0);
        send_beat(1'b0, pick_count(), pick_count(), $urandom, $urandom);

        drain();
        repeat (20) @(negedge clk);
        $display("Ran %0d samples and %0d target commands; %0d drive beats checked.",
                 samples_seen, commands_seen, drives_checked);
        $display("Covered gain extremes, a long receiver hold-off and a %0d-sample soak.",
                 SOAK_SAMPLES);
        if (mismatches == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
